[hdl/pcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared constants and types for the Paeth prediction codec.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 13;
    localparam int HEIGHT_BITS = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int VALUE_BITS  = 17;
    localparam int CFG_BITS    = 16;
    localparam int INDEX_BITS  = 2;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ADDR_BITS-1:0]   addr_t;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_DIRECTION    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } reg_index_t;

    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_REVERSE = 1'b1;

endpackage

[hdl/paeth_prediction_codec_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paeth_prediction_codec_core
// Raster-order Paeth predictor: samples to residuals or residuals back to
// samples, with the previous row kept in a single-port-read row memory.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | role
//  ----------+-----------------------------------------+--------------------
//  s_        | s_valid s_ready s_value_in              | sample or residual in
//  m_        | m_valid m_ready m_value_out m_end_of_image | residual or sample out
//  cfg_      | cfg_wr_en cfg_index cfg_wdata           | register writes
//
//  one transaction per clock unless the output stalls; input and output registered
//  the row memory read is issued at accept, its data used in the compute stage
//  together with the left sample, which closes the per-pixel loop
//  reset: direction forward, width 4096, height 1, positions zero; no memory pass
//  a stalled output holds the compute stage, which holds the input
// ----------------------------------------------------------------------------
module paeth_prediction_codec_core
    import pcc_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_value_out,
    output logic                         m_end_of_image,
    input  logic                         cfg_wr_en,
    input  logic [INDEX_BITS-1:0]        cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_wdata
);

    localparam int PB = SAMPLE_BITS + 3;

    sample_t                  row_mem [MAX_WIDTH];
    sample_t                  rd_reg;

    logic                     direction_reg;
    logic [WIDTH_BITS-1:0]    width_reg;
    logic [HEIGHT_BITS-1:0]   height_reg;

    addr_t                    col_reg, col_next;
    logic [HEIGHT_BITS-1:0]   row_reg, row_next;
    sample_t                  left_reg, left_next;
    sample_t                  ul_reg, ul_next;

    logic                     s1_valid_reg, s1_valid_next;
    logic [VALUE_BITS-1:0]    s1_value_reg;
    addr_t                    s1_col_reg;
    logic                     s1_row0_reg;
    logic                     s1_last_reg;
    logic                     s1_hit_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]    out_value_reg;
    logic                     out_eoi_reg;

    logic                     accept, advance, restart;
    logic [WIDTH_BITS-1:0]    w_eff;
    logic [HEIGHT_BITS-1:0]   h_eff;
    logic                     col_end, row_end, last;
    sample_t                  up, pred, sample;
    logic [VALUE_BITS-1:0]    result;
    logic signed [PB-1:0]     ax, bx, cx, d_a, d_b, d_c, m_a, m_b, m_c;

    assign restart = cfg_wr_en && (cfg_index == REG_DIRECTION ||
                     cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    assign advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // effective geometry
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (width_reg > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff   = (height_reg == '0) ? HEIGHT_BITS'(1) : height_reg;
        col_end = (WIDTH_BITS'(col_reg) + WIDTH_BITS'(1)) >= w_eff;
        row_end = ({1'b0, row_reg} + (HEIGHT_BITS+1)'(1)) >= {1'b0, h_eff};
        last    = col_end && row_end;
    end

    // raster position at the input side
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (last) begin
                col_next = '0;
                row_next = '0;
            end else if (col_end) begin
                col_next = '0;
                row_next = row_reg + HEIGHT_BITS'(1);
            end else begin
                col_next = col_reg + ADDR_BITS'(1);
            end
        end
    end

    // prediction and sample / residual
    always_comb begin
        up  = s1_hit_reg ? left_reg : rd_reg;
        ax  = PB'(signed'({1'b0, left_reg}));
        bx  = PB'(signed'({1'b0, up}));
        cx  = PB'(signed'({1'b0, ul_reg}));
        d_a = bx - cx;
        d_b = ax - cx;
        d_c = ax + bx - cx - cx;
        m_a = (d_a < 0) ? -d_a : d_a;
        m_b = (d_b < 0) ? -d_b : d_b;
        m_c = (d_c < 0) ? -d_c : d_c;

        if (s1_row0_reg) begin
            pred = (s1_col_reg == '0) ? '0 : left_reg;
        end else if (s1_col_reg == '0) begin
            pred = up;
        end else if (m_a <= m_b && m_a <= m_c) begin
            pred = left_reg;
        end else if (m_b <= m_c) begin
            pred = up;
        end else begin
            pred = ul_reg;
        end

        if (direction_reg == DIR_FORWARD) begin
            sample = s1_value_reg[SAMPLE_BITS-1:0];
            result = {{(VALUE_BITS-SAMPLE_BITS){1'b0}}, sample}
                   - {{(VALUE_BITS-SAMPLE_BITS){1'b0}}, pred};
        end else begin
            sample = s1_value_reg[SAMPLE_BITS-1:0] + pred;
            result = {{(VALUE_BITS-SAMPLE_BITS){1'b0}}, sample};
        end
    end

    always_comb begin
        left_next      = left_reg;
        ul_next        = ul_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (restart) begin
            left_next = '0;
            ul_next   = '0;
        end else if (advance) begin
            left_next = sample;
            ul_next   = up;
        end
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_FORWARD;
            width_reg     <= WIDTH_BITS'(MAX_WIDTH);
            height_reg    <= HEIGHT_BITS'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            ul_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_DIRECTION:    direction_reg <= cfg_wdata[0];
                    REG_IMAGE_WIDTH:  width_reg     <= cfg_wdata[WIDTH_BITS-1:0];
                    REG_IMAGE_HEIGHT: height_reg    <= cfg_wdata[HEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            ul_reg        <= ul_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // compute stage payload; hit flags a same-entry write at the read edge
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_value_reg <= s_value_in;
            s1_col_reg   <= col_reg;
            s1_row0_reg  <= (row_reg == '0);
            s1_last_reg  <= last;
            s1_hit_reg   <= advance && (s1_col_reg == col_reg);
        end
        if (advance) begin
            out_value_reg <= result;
            out_eoi_reg   <= s1_last_reg;
        end
    end

    // row memory
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= row_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            row_mem[s1_col_reg] <= sample;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_value_out    = signed'(out_value_reg);
    assign m_end_of_image = out_eoi_reg;

endmodule

[hdl/pcc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks for the Paeth prediction codec, bound to the top level.
// ----------------------------------------------------------------------------
module pcc_checker
    import pcc_pkg::*;
(
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [VALUE_BITS-1:0] m_value_out,
    input logic                         m_end_of_image
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_out) && $stable(m_end_of_image))
        else $error("result changed while stalled");

    // empty output means room at the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // a new result comes from an earlier input transaction
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input transaction");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind paeth_prediction_codec_core pcc_checker u_pcc_checker (.*);
